[rtl/vks_pkg.sv]
// Shared types, constants and state encoding for the vec3 keyframe sampler.
package vks_pkg;

    localparam int MAX_KEYS_DEF   = 64;
    localparam int RATIO_BITS_DEF = 16;
    localparam int DATA_W         = 32;
    localparam int KEY_COUNT_W    = 7;
    localparam int KEY_INDEX_W    = 6;
    localparam int APB_ADDR_W     = 3;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // Register index, taken from the word part of the byte address.
    localparam logic REG_KEY_COUNT = 1'b0;

    typedef struct packed {
        logic                     req_type;
        logic [KEY_INDEX_W-1:0]   key_index;
        logic signed [DATA_W-1:0] key_time;
        logic signed [DATA_W-1:0] key_x;
        logic signed [DATA_W-1:0] key_y;
        logic signed [DATA_W-1:0] key_z;
        logic                     key_step;
        logic signed [DATA_W-1:0] sample_time;
    } req_t;

    typedef struct packed {
        logic                     sample_valid;
        logic signed [DATA_W-1:0] out_x;
        logic signed [DATA_W-1:0] out_y;
        logic signed [DATA_W-1:0] out_z;
    } res_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] key_time;
        logic signed [DATA_W-1:0] key_x;
        logic signed [DATA_W-1:0] key_y;
        logic signed [DATA_W-1:0] key_z;
        logic                     key_step;
    } key_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHK_FIRST,
        ST_CHK_LAST,
        ST_SEARCH,
        ST_SEARCH_CMP,
        ST_RD_A,
        ST_RD_B,
        ST_GOT_B,
        ST_DIV,
        ST_MUL,
        ST_ADD
    } state_t;

    typedef enum logic [1:0] {
        LANE_X,
        LANE_Y,
        LANE_Z
    } lane_t;

endpackage

[rtl/vks_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/vks_divider.sv]
// Restoring divider producing a saturated RATIO_BITS-wide fraction, one bit per cycle.
module vks_divider #(
    parameter int RATIO_BITS = vks_pkg::RATIO_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [vks_pkg::DATA_W-1:0]    dividend,
    input  logic [vks_pkg::DATA_W-1:0]    divisor,
    output logic                          done,
    output logic [RATIO_BITS-1:0]         quotient
);

    localparam int DW = vks_pkg::DATA_W;
    localparam int CW = $clog2(RATIO_BITS);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [DW-1:0]     div_reg, div_next;
    logic [RATIO_BITS-1:0] quot_reg, quot_next;

    logic [DW:0] shifted;
    logic [DW:0] trial;
    logic        fits;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, div_reg};
    assign fits    = shifted >= {1'b0, div_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        quot_next = quot_reg;
        if (start)
        begin
            div_next = divisor;
            rem_next = dividend;
            cnt_next = '0;
            // A ratio of one or more saturates to the largest fraction.
            if (dividend >= divisor)
            begin
                quot_next = '1;
                done_next = 1'b1;
                run_next  = 1'b0;
            end
            else
            begin
                quot_next = '0;
                run_next  = 1'b1;
            end
        end
        else if (run_reg)
        begin
            rem_next  = fits ? trial[DW-1:0] : shifted[DW-1:0];
            quot_next = {quot_reg[RATIO_BITS-2:0], fits};
            cnt_next  = cnt_reg + CW'(1);
            if (cnt_reg == CW'(RATIO_BITS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

[rtl/vec3_keyframe_sampler.sv]
// Top level: keyframe table, binary-search sequencer and shared interpolation datapath.
// Keyframe writes complete at acceptance and never raise busy; an empty track strobes
// its result in the cycle after acceptance. A clamped sample is decided in ST_CHK_FIRST
// or ST_CHK_LAST. An interpolated sample searches the table through its single read
// port and may then run the bit-serial divider; one sample
// is in flight at a time. Reset clears key_count and the sequencer; table contents stay
// undefined until written. Results cannot be stalled and are strobed by done.
module vec3_keyframe_sampler #(
    parameter int MAX_KEYS   = vks_pkg::MAX_KEYS_DEF,
    parameter int RATIO_BITS = vks_pkg::RATIO_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  vks_pkg::req_t                     req,
    output logic                              busy,
    output logic                              done,
    output vks_pkg::res_t                     result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [vks_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [vks_pkg::DATA_W-1:0]        pwdata,
    output logic [vks_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    localparam int DW     = vks_pkg::DATA_W;
    localparam int KCW    = vks_pkg::KEY_COUNT_W;
    localparam int AW     = $clog2(MAX_KEYS);
    localparam int CNT_W  = $clog2(MAX_KEYS + 1);
    localparam int ENT_W  = $bits(vks_pkg::key_entry_t);
    localparam int PROD_W = DW + RATIO_BITS + 2;

    // Configuration register.
    logic [KCW-1:0] key_count_reg;
    logic           cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[vks_pkg::APB_ADDR_W-1] == vks_pkg::REG_KEY_COUNT);
    assign prdata    = (paddr[vks_pkg::APB_ADDR_W-1] == vks_pkg::REG_KEY_COUNT)
                       ? {{(DW-KCW){1'b0}}, key_count_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            key_count_reg <= pwdata[KCW-1:0];
        end
    end

    // Sequencer and datapath registers.
    vks_pkg::state_t     state_reg, state_next;
    logic                done_reg, done_next;
    vks_pkg::res_t       result_reg, result_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic signed [DW-1:0] t_reg, t_next;
    logic [CNT_W-1:0]    lo_reg, lo_next;
    logic [CNT_W-1:0]    hi_reg, hi_next;
    logic [CNT_W-1:0]    mid_reg, mid_next;
    logic [CNT_W-1:0]    ib_reg, ib_next;
    vks_pkg::key_entry_t a_reg, a_next;
    vks_pkg::key_entry_t b_reg, b_next;
    logic [RATIO_BITS-1:0] ratio_reg, ratio_next;
    vks_pkg::lane_t      lane_reg, lane_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;

    // Table memory.
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       rd_addr;
    logic [ENT_W-1:0]    ram_rdata;
    vks_pkg::key_entry_t wr_entry;
    vks_pkg::key_entry_t rd_entry;

    // Divider handshake.
    logic                  div_start;
    logic                  div_done;
    logic [RATIO_BITS-1:0] div_quot;
    logic [DW-1:0]         div_dividend;
    logic [DW-1:0]         div_divisor;

    logic                 accept;
    logic [CNT_W-1:0]     n_calc;
    logic [CNT_W-1:0]     mid_calc;
    logic [CNT_W-1:0]     ib_calc;
    logic                 t_le_key;
    logic                 t_ge_key;
    logic                 t_lt_key;
    logic                 lerp_ok;
    logic signed [DW-1:0] a_lane;
    logic signed [DW-1:0] b_lane;
    logic signed [DW:0]   lane_diff;
    logic signed [RATIO_BITS:0] ratio_s;
    logic signed [DW-1:0] lane_sum;

    assign busy   = (state_reg != vks_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign ram_we    = accept && (req.req_type == vks_pkg::REQ_WRITE)
                       && (32'(req.key_index) < 32'(MAX_KEYS));
    assign ram_waddr = AW'(req.key_index);
    assign wr_entry  = '{key_time: req.key_time, key_x: req.key_x, key_y: req.key_y,
                         key_z: req.key_z, key_step: req.key_step};
    assign rd_entry  = vks_pkg::key_entry_t'(ram_rdata);

    vks_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign div_dividend = DW'(t_reg - a_reg.key_time);
    assign div_divisor  = DW'(rd_entry.key_time - a_reg.key_time);

    vks_divider #(
        .RATIO_BITS (RATIO_BITS)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // A key_count beyond the table size counts as a full table.
    assign n_calc = (32'(key_count_reg) > 32'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                          : CNT_W'(key_count_reg);
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        if (lo_reg == '0)
        begin
            ib_calc = CNT_W'(1);
        end
        else if (lo_reg > n_reg - CNT_W'(1))
        begin
            ib_calc = n_reg - CNT_W'(1);
        end
        else
        begin
            ib_calc = lo_reg;
        end
    end

    assign t_le_key = t_reg <= rd_entry.key_time;
    assign t_ge_key = t_reg >= rd_entry.key_time;
    assign t_lt_key = t_reg <  rd_entry.key_time;
    assign lerp_ok  = (rd_entry.key_time > a_reg.key_time) && (t_reg >= a_reg.key_time);

    always_comb
    begin
        unique case (lane_reg)
            vks_pkg::LANE_X:
            begin
                a_lane = a_reg.key_x;
                b_lane = b_reg.key_x;
            end
            vks_pkg::LANE_Y:
            begin
                a_lane = a_reg.key_y;
                b_lane = b_reg.key_y;
            end
            vks_pkg::LANE_Z:
            begin
                a_lane = a_reg.key_z;
                b_lane = b_reg.key_z;
            end
            default:
            begin
                a_lane = a_reg.key_x;
                b_lane = b_reg.key_x;
            end
        endcase
    end

    assign lane_diff = {b_lane[DW-1], b_lane} - {a_lane[DW-1], a_lane};
    assign ratio_s   = {1'b0, ratio_reg};
    // The product's bits above the fraction are the floored quotient by 2^RATIO_BITS.
    assign lane_sum  = a_lane + prod_reg[RATIO_BITS +: DW];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vks_pkg::ST_IDLE:
            begin
                if (accept && (req.req_type == vks_pkg::REQ_SAMPLE) && (n_calc != '0))
                begin
                    state_next = vks_pkg::ST_CHK_FIRST;
                end
            end
            vks_pkg::ST_CHK_FIRST:
            begin
                state_next = t_le_key ? vks_pkg::ST_IDLE : vks_pkg::ST_CHK_LAST;
            end
            vks_pkg::ST_CHK_LAST:
            begin
                state_next = t_ge_key ? vks_pkg::ST_IDLE : vks_pkg::ST_SEARCH;
            end
            vks_pkg::ST_SEARCH:
            begin
                state_next = (lo_reg < hi_reg) ? vks_pkg::ST_SEARCH_CMP : vks_pkg::ST_RD_A;
            end
            vks_pkg::ST_SEARCH_CMP:
            begin
                state_next = vks_pkg::ST_SEARCH;
            end
            vks_pkg::ST_RD_A:
            begin
                state_next = vks_pkg::ST_RD_B;
            end
            vks_pkg::ST_RD_B:
            begin
                state_next = vks_pkg::ST_GOT_B;
            end
            vks_pkg::ST_GOT_B:
            begin
                priority if (a_reg.key_step)
                begin
                    state_next = vks_pkg::ST_IDLE;
                end
                else if (lerp_ok)
                begin
                    state_next = vks_pkg::ST_DIV;
                end
                else
                begin
                    state_next = vks_pkg::ST_MUL;
                end
            end
            vks_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = vks_pkg::ST_MUL;
                end
            end
            vks_pkg::ST_MUL:
            begin
                state_next = vks_pkg::ST_ADD;
            end
            vks_pkg::ST_ADD:
            begin
                state_next = (lane_reg == vks_pkg::LANE_Z) ? vks_pkg::ST_IDLE
                                                            : vks_pkg::ST_MUL;
            end
            default:
            begin
                state_next = vks_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates, read address and result beat.
    always_comb
    begin
        done_next   = 1'b0;
        result_next = result_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        ib_next     = ib_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        ratio_next  = ratio_reg;
        lane_next   = lane_reg;
        prod_next   = prod_reg;
        rd_addr     = '0;
        div_start   = 1'b0;
        unique case (state_reg)
            vks_pkg::ST_IDLE:
            begin
                // The first key is read while the request is taken.
                if (accept && (req.req_type == vks_pkg::REQ_SAMPLE))
                begin
                    t_next = req.sample_time;
                    n_next = n_calc;
                    if (n_calc == '0)
                    begin
                        done_next   = 1'b1;
                        result_next = '0;
                    end
                end
            end
            vks_pkg::ST_CHK_FIRST:
            begin
                if (t_le_key)
                begin
                    done_next   = 1'b1;
                    result_next = '{sample_valid: 1'b1, out_x: rd_entry.key_x,
                                    out_y: rd_entry.key_y, out_z: rd_entry.key_z};
                end
                else
                begin
                    rd_addr = AW'(n_reg - CNT_W'(1));
                end
            end
            vks_pkg::ST_CHK_LAST:
            begin
                if (t_ge_key)
                begin
                    done_next   = 1'b1;
                    result_next = '{sample_valid: 1'b1, out_x: rd_entry.key_x,
                                    out_y: rd_entry.key_y, out_z: rd_entry.key_z};
                end
                else
                begin
                    lo_next = '0;
                    hi_next = n_reg;
                end
            end
            vks_pkg::ST_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr  = AW'(mid_calc);
                    mid_next = mid_calc;
                end
                else
                begin
                    ib_next = ib_calc;
                end
            end
            vks_pkg::ST_SEARCH_CMP:
            begin
                if (t_lt_key)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + CNT_W'(1);
                end
            end
            vks_pkg::ST_RD_A:
            begin
                rd_addr = AW'(ib_reg - CNT_W'(1));
            end
            vks_pkg::ST_RD_B:
            begin
                a_next  = rd_entry;
                rd_addr = AW'(ib_reg);
            end
            vks_pkg::ST_GOT_B:
            begin
                b_next    = rd_entry;
                lane_next = vks_pkg::LANE_X;
                priority if (a_reg.key_step)
                begin
                    done_next   = 1'b1;
                    result_next = '{sample_valid: 1'b1, out_x: a_reg.key_x,
                                    out_y: a_reg.key_y, out_z: a_reg.key_z};
                end
                else if (lerp_ok)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    ratio_next = '0;
                end
            end
            vks_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    ratio_next = div_quot;
                end
            end
            vks_pkg::ST_MUL:
            begin
                prod_next = lane_diff * ratio_s;
            end
            vks_pkg::ST_ADD:
            begin
                result_next.sample_valid = 1'b1;
                unique case (lane_reg)
                    vks_pkg::LANE_X:
                    begin
                        result_next.out_x = lane_sum;
                        lane_next         = vks_pkg::LANE_Y;
                    end
                    vks_pkg::LANE_Y:
                    begin
                        result_next.out_y = lane_sum;
                        lane_next         = vks_pkg::LANE_Z;
                    end
                    vks_pkg::LANE_Z:
                    begin
                        result_next.out_z = lane_sum;
                        done_next         = 1'b1;
                    end
                    default:
                    begin
                        lane_next = vks_pkg::LANE_X;
                    end
                endcase
            end
            default:
            begin
                rd_addr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vks_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        n_reg      <= n_next;
        t_reg      <= t_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        ib_reg     <= ib_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        ratio_reg  <= ratio_next;
        lane_reg   <= lane_next;
        prod_reg   <= prod_next;
    end

endmodule

[test/tb_vec3_keyframe_sampler.sv]
// Self-checking testbench for the vec3 keyframe sampler: table loads, track settings and samples.
module tb_vec3_keyframe_sampler;
    import vks_pkg::*;

    localparam int MAX_KEYS    = MAX_KEYS_DEF;
    localparam int RATIO_BITS  = RATIO_BITS_DEF;
    localparam longint unsigned RATIO_MAX = (64'd1 << RATIO_BITS) - 1;
    localparam longint T_MAX   = 64'sh0000_0000_7FFF_FFFF;
    localparam longint T_MIN   = -64'sh0000_0000_8000_0000;
    localparam int IDLE_PCT    = 23;
    localparam int ITEM_TARGET = 1350;
    localparam int CYCLE_LIMIT = 800000;
    localparam int DRAIN_CYCLES = 60;
    localparam logic [APB_ADDR_W-1:0] KEY_COUNT_ADDR = APB_ADDR_W'(4 * REG_KEY_COUNT);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    req_t req = '0;
    logic busy;
    logic done;
    res_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    // Predictor state: the key table and key_count as the block should hold them.
    key_entry_t track_keys [MAX_KEYS];
    logic [KEY_COUNT_W-1:0] track_count = '0;

    // Stimulus side: key times as planned, used to aim samples at the track.
    longint plan_time [MAX_KEYS];

    req_t pending_reqs[$];
    res_t due_samples[$];
    res_t want_res;
    bit steady = 1'b0;

    int cycle_cnt = 0;
    int n_errors = 0;
    int n_queued = 0;
    int n_writes = 0;
    int n_samples = 0;
    int n_results = 0;
    int n_settings = 0;

    vec3_keyframe_sampler dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .req(req),
        .busy(busy),
        .done(done),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_cnt <= cycle_cnt + 1;

    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d samples outstanding",
                 cycle_cnt, due_samples.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_errors++;
        if (n_errors <= 30)
            $display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
    endtask

    task automatic check_field(input string name, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %h want %h", n_results, name, got, want));
    endtask

    // Linear blend of one lane; the shift floors toward minus infinity.
    function automatic logic [DATA_W-1:0] blend_lane(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b,
                                                     input longint unsigned frac);
        longint prod;
        prod = (longint'(b) - longint'(a)) * longint'(frac);
        return DATA_W'(longint'(a) + (prod >>> RATIO_BITS));
    endfunction

    function automatic res_t sample_track(input logic signed [DATA_W-1:0] t);
        res_t r;
        int n, lo, hi, mid, ia, ib;
        longint ta, tb;
        longint unsigned span, dt, frac;
        r = '0;
        frac = 0;
        n = (int'(track_count) > MAX_KEYS) ? MAX_KEYS : int'(track_count);
        if (n == 0)
            return r;
        r.sample_valid = 1'b1;
        if (t <= $signed(track_keys[0].key_time))
        begin
            ia = 0;
            ib = 0;
        end
        else if (t >= $signed(track_keys[n-1].key_time))
        begin
            ia = n - 1;
            ib = n - 1;
        end
        else
        begin
            // Upper bound: first slot whose time is above t.
            lo = 0;
            hi = n;
            while (lo < hi)
            begin
                mid = lo + (hi - lo) / 2;
                if (t < $signed(track_keys[mid].key_time))
                    hi = mid;
                else
                    lo = mid + 1;
            end
            ib = (lo == 0) ? 1 : lo;
            if (ib > n - 1)
                ib = n - 1;
            ia = ib - 1;
            if (track_keys[ia].key_step)
                ib = ia;
            else
            begin
                ta = longint'($signed(track_keys[ia].key_time));
                tb = longint'($signed(track_keys[ib].key_time));
                if (tb > ta && longint'(t) >= ta)
                begin
                    span = tb - ta;
                    dt = longint'(t) - ta;
                    frac = (dt << RATIO_BITS) / span;
                    if (frac > RATIO_MAX)
                        frac = RATIO_MAX;
                end
            end
        end
        r.out_x = blend_lane(track_keys[ia].key_x, track_keys[ib].key_x, frac);
        r.out_y = blend_lane(track_keys[ia].key_y, track_keys[ib].key_y, frac);
        r.out_z = blend_lane(track_keys[ia].key_z, track_keys[ib].key_z, frac);
        return r;
    endfunction

    // Request driver: a beat is taken when start is high and busy is low.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                if (req.req_type == REQ_WRITE)
                begin
                    track_keys[req.key_index] = '{req.key_time, req.key_x, req.key_y,
                                                  req.key_z, req.key_step};
                    n_writes++;
                end
                else
                begin
                    due_samples.push_back(sample_track(req.sample_time));
                    n_samples++;
                end
            end
            if (!start || !busy)
            begin
                if (pending_reqs.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    start <= 1'b1;
                    req <= pending_reqs.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Result monitor: every strobe must match the oldest outstanding sample.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (due_samples.size() == 0)
                report_mismatch("result strobe with no sample outstanding");
            else
            begin
                want_res = due_samples.pop_front();
                check_field("sample_valid", DATA_W'(result.sample_valid),
                            DATA_W'(want_res.sample_valid));
                check_field("out_x", result.out_x, want_res.out_x);
                check_field("out_y", result.out_y, want_res.out_y);
                check_field("out_z", result.out_z, want_res.out_z);
            end
            n_results++;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_q16();
        logic signed [DATA_W-1:0] v;
        v = $urandom();
        if ($urandom_range(1) == 0)
            v = v >>> $urandom_range(31, 1);
        return v;
    endfunction

    task automatic add_key(input int slot, input logic signed [DATA_W-1:0] t,
                           input logic signed [DATA_W-1:0] x, input logic signed [DATA_W-1:0] y,
                           input logic signed [DATA_W-1:0] z, input logic step);
        req_t r;
        r.req_type = REQ_WRITE;
        r.key_index = KEY_INDEX_W'(slot);
        r.key_time = t;
        r.key_x = x;
        r.key_y = y;
        r.key_z = z;
        r.key_step = step;
        r.sample_time = $urandom();
        pending_reqs.push_back(r);
        plan_time[slot] = longint'(t);
        n_queued++;
    endtask

    task automatic add_sample(input logic signed [DATA_W-1:0] t);
        req_t r;
        r.req_type = REQ_SAMPLE;
        r.key_index = KEY_INDEX_W'($urandom());
        r.key_time = $urandom();
        r.key_x = $urandom();
        r.key_y = $urandom();
        r.key_z = $urandom();
        r.key_step = $urandom_range(1);
        r.sample_time = t;
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // Waits for the block to go quiet, then writes key_count and reads it back.
    task automatic set_track_count(input int value);
        logic [KEY_COUNT_W-1:0] v;
        v = KEY_COUNT_W'(value);
        @(negedge clk);
        while (pending_reqs.size() != 0 || start || due_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= KEY_COUNT_ADDR;
        pwdata <= DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (prdata !== DATA_W'(v))
            report_mismatch($sformatf("key_count read back %h want %h", prdata, DATA_W'(v)));
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        track_count = v;
        n_settings++;
        @(negedge clk);
    endtask

    task automatic load_track(input int n, input bit sorted);
        longint t, gap_max;
        case ($urandom_range(2))
            0: gap_max = 16;
            1: gap_max = 'h2_0000;
            default: gap_max = 'h400_0000;
        endcase
        t = longint'(rand_q16());
        for (int i = 0; i < n; i++)
        begin
            if (!sorted)
                t = longint'(rand_q16());
            if (t > T_MAX)
                t = T_MAX;
            add_key(i, DATA_W'(t), rand_q16(), rand_q16(), rand_q16(), $urandom_range(3) == 0);
            t += longint'($urandom_range(int'(gap_max)));
        end
    endtask

    // Samples aimed mostly inside the current track, with a few stray key rewrites.
    task automatic add_samples(input int k);
        int nk, idx, pick;
        longint lo, hi, margin, t;
        nk = (int'(track_count) > MAX_KEYS) ? MAX_KEYS : int'(track_count);
        for (int s = 0; s < k; s++)
        begin
            if (nk == 0)
                t = longint'(rand_q16());
            else
            begin
                lo = plan_time[0];
                hi = plan_time[nk-1];
                if (lo > hi)
                begin
                    t = lo;
                    lo = hi;
                    hi = t;
                end
                margin = (hi - lo) / 8 + 2;
                idx = $urandom_range(nk - 1);
                pick = $urandom_range(99);
                if (pick < 65)
                    t = lo - margin + longint'({$urandom(), $urandom()} % (hi - lo + 2 * margin + 1));
                else if (pick < 80)
                    t = plan_time[idx];
                else if (pick < 90)
                    t = plan_time[idx] + ($urandom_range(1) ? 1 : -1);
                else
                    t = longint'(rand_q16());
            end
            if (t > T_MAX)
                t = T_MAX;
            if (t < T_MIN)
                t = T_MIN;
            add_sample(DATA_W'(t));
            if ($urandom_range(99) < 4)
                add_key($urandom_range(MAX_KEYS - 1), rand_q16(), rand_q16(), rand_q16(),
                        rand_q16(), $urandom_range(1));
        end
    endtask

    initial
    begin
        int pick, n, phase;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty track out of reset, then a four-key track spanning the whole time range.
        add_sample(32'sh8000_0000);
        add_sample(32'sh7FFF_FFFF);
        add_key(0, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000, 1'b0);
        add_key(1, 32'sh0000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b1);
        add_key(2, 32'sh0001_0000, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0000_0001, 1'b0);
        add_key(3, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0001_0000, 32'sh8000_0001, 1'b0);
        add_key(MAX_KEYS - 1, 32'sh1234_5678, rand_q16(), rand_q16(), rand_q16(), 1'b1);
        set_track_count(4);
        add_sample(32'sh8000_0000);
        add_sample(32'sh7FFF_FFFF);
        add_sample(32'sh8000_0001);
        add_sample(-32'sh1);
        add_sample(32'sh0000_0000);
        add_sample(32'sh0000_8000);
        add_sample(32'sh0001_8000);
        add_sample(32'sh7FFF_FFFE);
        // Two keys at the same time.
        add_key(2, 32'sh0000_0000, 32'sh0003_0000, 32'shFFFD_0000, 32'sh0000_0001, 1'b0);
        add_sample(32'sh0000_0000);
        set_track_count(1);
        add_sample(32'sh8000_0000);
        add_sample(32'sh7FFF_FFFF);

        // Fill the whole table so that every count is legal from here on.
        set_track_count(MAX_KEYS);
        load_track(MAX_KEYS, 1'b1);
        add_samples(40);
        set_track_count(127);
        add_samples(20);
        set_track_count(0);
        add_samples(8);

        phase = 0;
        while (n_queued < ITEM_TARGET)
        begin
            steady = (phase >= 3 && phase < 6);
            pick = $urandom_range(99);
            if (pick < 60)
            begin
                n = $urandom_range(8, 1);
                set_track_count(n);
                load_track(n, 1'b1);
                add_samples(30);
            end
            else if (pick < 75)
            begin
                n = $urandom_range(MAX_KEYS, 9);
                set_track_count(n);
                load_track(n, 1'b1);
                add_samples(30);
            end
            else if (pick < 85)
            begin
                n = $urandom_range(16, 2);
                set_track_count(n);
                load_track(n, 1'b0);
                add_samples(20);
            end
            else
            begin
                case ($urandom_range(2))
                    0: n = 0;
                    1: n = $urandom_range(MAX_KEYS, 1);
                    default: n = $urandom_range(127, MAX_KEYS + 1);
                endcase
                set_track_count(n);
                add_samples(15);
            end
            phase++;
        end

        @(negedge clk);
        while (pending_reqs.size() != 0 || start || due_samples.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Loaded %0d keyframes and took %0d samples across %0d key_count settings.",
                 n_writes, n_samples, n_settings);
        $display("Checked %0d results, %0d mismatches, %0d cycles.", n_results, n_errors, cycle_cnt);
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
